### hdl/occupancy_grid_neighbor_expander_core_defines.svh
// ----------------------------------------------------------------------------
// Occupancy grid neighbor expander: assertion macros
// Shared assertion helpers; define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_NEIGHBOR_EXPANDER_CORE_DEFINES_SVH
`define OCCUPANCY_GRID_NEIGHBOR_EXPANDER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define OGNE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Expression must never be true outside reset
`define OGNE_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define OGNE_ASSERT(lbl, clk, rst_n, prop)
`define OGNE_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### hdl/ogne_pkg.sv
// ----------------------------------------------------------------------------
// ogne_pkg
// Shared types, command codes and neighbor step tables of the expander.
// ----------------------------------------------------------------------------
package ogne_pkg;

    // Command codes of an input transaction
    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_NBR   = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } t_reg_idx;

    localparam int          CFG_W       = 9;
    localparam logic [8:0]  CFG_RST_VAL = 9'd256;

    // Signed coordinate wide enough for -1 .. 256
    localparam int COORD_W = 10;
    typedef logic signed [COORD_W-1:0] t_coord;

    // Neighbor step order
    localparam logic [2:0] STEP_UP         = 3'd0;
    localparam logic [2:0] STEP_RIGHT      = 3'd1;
    localparam logic [2:0] STEP_DOWN       = 3'd2;
    localparam logic [2:0] STEP_LEFT       = 3'd3;
    localparam logic [2:0] STEP_UP_LEFT    = 3'd4;
    localparam logic [2:0] STEP_UP_RIGHT   = 3'd5;
    localparam logic [2:0] STEP_DOWN_RIGHT = 3'd6;
    localparam logic [2:0] STEP_DOWN_LEFT  = 3'd7;

    // Row offset of a step
    function automatic logic signed [1:0] step_row(input logic [2:0] k);
        case (k)
            STEP_UP, STEP_UP_LEFT, STEP_UP_RIGHT:       step_row = -2'sd1;
            STEP_DOWN, STEP_DOWN_RIGHT, STEP_DOWN_LEFT: step_row = 2'sd1;
            default:                                    step_row = 2'sd0;
        endcase
    endfunction

    // Column offset of a step
    function automatic logic signed [1:0] step_col(input logic [2:0] k);
        case (k)
            STEP_LEFT, STEP_UP_LEFT, STEP_DOWN_LEFT:    step_col = -2'sd1;
            STEP_RIGHT, STEP_UP_RIGHT, STEP_DOWN_RIGHT: step_col = 2'sd1;
            default:                                    step_col = 2'sd0;
        endcase
    endfunction

    // Cardinal cell sharing the diagonal's row (up or down)
    function automatic logic [1:0] diag_row_card(input logic [2:0] k);
        case (k)
            STEP_UP_LEFT, STEP_UP_RIGHT: diag_row_card = STEP_UP[1:0];
            default:                     diag_row_card = STEP_DOWN[1:0];
        endcase
    endfunction

    // Cardinal cell sharing the diagonal's column (left or right)
    function automatic logic [1:0] diag_col_card(input logic [2:0] k);
        case (k)
            STEP_UP_LEFT, STEP_DOWN_LEFT: diag_col_card = STEP_LEFT[1:0];
            default:                      diag_col_card = STEP_RIGHT[1:0];
        endcase
    endfunction

    // Sequencer states
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SET   = 7'b0000010,
        ST_QRD   = 7'b0000100,
        ST_QRSP  = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_FLUSH = 7'b1000000
    } t_state;

endpackage

### hdl/ogne_cell_unit.sv
// ----------------------------------------------------------------------------
// ogne_cell_unit
// Shared bounds check and map address generation for one candidate cell.
// ----------------------------------------------------------------------------
module ogne_cell_unit #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256,
    parameter int AW       = 16
) (
    input  ogne_pkg::t_coord                 i_row,
    input  ogne_pkg::t_coord                 i_col,
    input  logic [ogne_pkg::CFG_W-1:0]       i_row_count,
    input  logic [ogne_pkg::CFG_W-1:0]       i_col_count,
    output logic                             o_inside,
    output logic [AW-1:0]                    o_addr
);

    localparam int         PW      = AW + ogne_pkg::CFG_W + 1;
    localparam logic [12:0] ROW_LIM = 13'(MAX_ROWS);
    localparam logic [12:0] COL_LIM = 13'(MAX_COLS);

    logic [ogne_pkg::CFG_W-1:0] row_u;
    logic [ogne_pkg::CFG_W-1:0] col_u;
    logic [PW-1:0]              addr_full;

    assign row_u = i_row[ogne_pkg::CFG_W-1:0];
    assign col_u = i_col[ogne_pkg::CFG_W-1:0];

    // In bounds: non-negative, below the register and below the map size
    assign o_inside = !i_row[ogne_pkg::COORD_W-1] && !i_col[ogne_pkg::COORD_W-1] &&
                      (row_u < i_row_count) && (col_u < i_col_count) &&
                      ({4'd0, row_u} < ROW_LIM) && ({4'd0, col_u} < COL_LIM);

    // Row-major address; only meaningful when in bounds
    assign addr_full = PW'(row_u) * PW'(MAX_COLS) + PW'(col_u);
    assign o_addr    = addr_full[AW-1:0];

endmodule

### hdl/ogne_cell_map.sv
// ----------------------------------------------------------------------------
// ogne_cell_map
// One-bit blocked map with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module ogne_cell_map #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic          i_wdata,
    input  logic          i_re,
    output logic          o_rdata,
    output logic          o_clearing
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic          mem [DEPTH];
    logic          r_clearing;
    logic          n_clearing;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] n_clr_addr;
    logic          r_rdata;

    // Clearing sweep, one entry per cycle
    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    // Storage: sweep writes win, reads are registered
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= 1'b0;
        end else if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

### hdl/occupancy_grid_neighbor_expander_core.sv
// ----------------------------------------------------------------------------
// occupancy_grid_neighbor_expander_core
// Blocked-cell map with set, query and free-neighbor listing commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one command per
//   transaction. Output channel (o_out_valid / i_out_ready) returns the
//   results; o_out_last marks the final result of a command.
//   Set: one result. Query: one result. Neighbor list: one map read per
//   candidate through a single shared bounds/address unit and one map
//   read port, over 4 candidates (8 with diagonal). Each free neighbor
//   is passed out when the next one is found or the scan ends.
//   Unused command code: one empty result.
//   A command is accepted only when the previous one has been fully
//   handed to the output register; the final result may still be waiting.
// Reset:
//   Bounds return to 256 x 256 and a clearing sweep writes every map entry
//   free, during which o_in_ready stays low.
//   Configuration writes are taken at any time.
// Stalls:
//   When i_out_ready is low the output register holds; a neighbor scan
//   pauses on a further free neighbor until the pending result can move on.
// ----------------------------------------------------------------------------
`include "occupancy_grid_neighbor_expander_core_defines.svh"

module occupancy_grid_neighbor_expander_core #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_index,
    input  logic [ogne_pkg::CFG_W-1:0]   i_cfg_data,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_in_cmd,
    input  logic [7:0]                   i_in_cell_row,
    input  logic [7:0]                   i_in_cell_col,
    input  logic                         i_in_new_blocked,
    input  logic                         i_in_diagonal,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_out_status,
    output logic                         o_out_cell_blocked,
    output logic                         o_out_found,
    output logic [7:0]                   o_out_nbr_row,
    output logic [7:0]                   o_out_nbr_col,
    output logic                         o_out_last
);

    localparam int MAP_CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW        = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    ogne_pkg::t_state             r_state, n_state;
    logic [ogne_pkg::CFG_W-1:0]   r_row_count, r_col_count;
    logic [7:0]                   r_row, r_col;
    logic                         r_nb, r_diag;
    logic [2:0]                   r_step, n_step;
    logic [3:0]                   r_card, n_card;
    logic                         r_ev_valid, n_ev_valid;
    logic                         r_ev_inside;
    logic [2:0]                   r_ev_step;
    logic [7:0]                   r_ev_row, r_ev_col;
    logic                         r_pend_valid, n_pend_valid;
    logic [7:0]                   r_pend_row, n_pend_row;
    logic [7:0]                   r_pend_col, n_pend_col;
    logic                         r_out_valid;
    logic                         r_out_status, r_out_cell_blocked, r_out_found, r_out_last;
    logic [7:0]                   r_out_row, r_out_col;

    logic                         in_accept;
    logic                         out_free;
    logic                         stall, adv;
    logic signed [1:0]            dr, dc;
    ogne_pkg::t_coord             cand_row, cand_col;
    logic                         cand_inside;
    logic [AW-1:0]                cand_addr;
    logic                         map_we, map_rdata, map_clearing;
    logic                         ev_open, ev_ok;
    logic [2:0]                   last_step;
    logic                         out_load;
    logic                         out_status, out_cell_blocked, out_found, out_last;
    logic [7:0]                   out_row, out_col;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ogne_pkg::CFG_RST_VAL;
            r_col_count <= ogne_pkg::CFG_RST_VAL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ogne_pkg::REG_ROW_COUNT: r_row_count <= i_cfg_data;
                ogne_pkg::REG_COL_COUNT: r_col_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign o_in_ready = (r_state == ogne_pkg::ST_IDLE) && !map_clearing;
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------
    // Candidate cell through the shared unit
    // ------------------------------------------------------------------
    always_comb begin
        dr = 2'sd0;
        dc = 2'sd0;
        if (r_state == ogne_pkg::ST_SCAN) begin
            dr = ogne_pkg::step_row(r_step);
            dc = ogne_pkg::step_col(r_step);
        end
    end

    assign cand_row = $signed({2'b00, r_row}) + $signed({{8{dr[1]}}, dr});
    assign cand_col = $signed({2'b00, r_col}) + $signed({{8{dc[1]}}, dc});

    ogne_cell_unit #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .AW       (AW)
    ) u_cell_unit (
        .i_row       (cand_row),
        .i_col       (cand_col),
        .i_row_count (r_row_count),
        .i_col_count (r_col_count),
        .o_inside    (cand_inside),
        .o_addr      (cand_addr)
    );

    assign map_we = (r_state == ogne_pkg::ST_SET) && cand_inside && out_free;

    ogne_cell_map #(
        .DEPTH (MAP_CELLS),
        .AW    (AW)
    ) u_cell_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (map_we),
        .i_addr     (cand_addr),
        .i_wdata    (r_nb),
        .i_re       (adv),
        .o_rdata    (map_rdata),
        .o_clearing (map_clearing)
    );

    // ------------------------------------------------------------------
    // Evaluate stage: free test, corner-cut rule, stall
    // ------------------------------------------------------------------
    assign ev_open = r_ev_inside && !map_rdata;
    assign ev_ok   = r_ev_step[2] ?
                     (ev_open && r_card[ogne_pkg::diag_row_card(r_ev_step)] &&
                      r_card[ogne_pkg::diag_col_card(r_ev_step)]) : ev_open;
    assign stall   = r_ev_valid && ev_ok && r_pend_valid && !out_free;
    assign adv     = !stall;

    assign last_step = r_diag ? ogne_pkg::STEP_DOWN_LEFT : ogne_pkg::STEP_LEFT;

    // ------------------------------------------------------------------
    // Sequencer and result selection
    // ------------------------------------------------------------------
    always_comb begin
        n_state          = r_state;
        n_step           = r_step;
        n_card           = r_card;
        n_ev_valid       = r_ev_valid;
        n_pend_valid     = r_pend_valid;
        n_pend_row       = r_pend_row;
        n_pend_col       = r_pend_col;
        out_load         = 1'b0;
        out_status       = 1'b0;
        out_cell_blocked = 1'b0;
        out_found        = 1'b0;
        out_row          = 8'd0;
        out_col          = 8'd0;
        out_last         = 1'b1;

        // evaluated neighbor: forward the older pending one, keep the new
        if (r_ev_valid && adv) begin
            if (!r_ev_step[2]) begin
                n_card[r_ev_step[1:0]] = ev_open;
            end
            if (ev_ok) begin
                if (r_pend_valid) begin
                    out_load  = 1'b1;
                    out_found = 1'b1;
                    out_row   = r_pend_row;
                    out_col   = r_pend_col;
                    out_last  = 1'b0;
                end
                n_pend_valid = 1'b1;
                n_pend_row   = r_ev_row;
                n_pend_col   = r_ev_col;
            end
        end
        if (adv) begin
            n_ev_valid = (r_state == ogne_pkg::ST_SCAN);
        end

        case (r_state)
            ogne_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_step       = ogne_pkg::STEP_UP;
                    n_card       = 4'd0;
                    n_pend_valid = 1'b0;
                    case (i_in_cmd)
                        ogne_pkg::CMD_SET:   n_state = ogne_pkg::ST_SET;
                        ogne_pkg::CMD_QUERY: n_state = ogne_pkg::ST_QRD;
                        ogne_pkg::CMD_NBR:   n_state = ogne_pkg::ST_SCAN;
                        default:             n_state = ogne_pkg::ST_FLUSH;
                    endcase
                end
            end
            ogne_pkg::ST_SET: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = !cand_inside;
                    n_state    = ogne_pkg::ST_IDLE;
                end
            end
            ogne_pkg::ST_QRD: begin
                n_state = ogne_pkg::ST_QRSP;
            end
            ogne_pkg::ST_QRSP: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    out_status       = !r_ev_inside;
                    out_cell_blocked = r_ev_inside && map_rdata;
                    n_state          = ogne_pkg::ST_IDLE;
                end
            end
            ogne_pkg::ST_SCAN: begin
                if (adv) begin
                    n_step = r_step + 3'd1;
                    if (r_step == last_step) begin
                        n_state = ogne_pkg::ST_DRAIN;
                    end
                end
            end
            ogne_pkg::ST_DRAIN: begin
                if (adv) begin
                    n_state = ogne_pkg::ST_FLUSH;
                end
            end
            ogne_pkg::ST_FLUSH: begin
                // final result: last pending neighbor, or one empty result
                if (out_free) begin
                    out_load     = 1'b1;
                    out_found    = r_pend_valid;
                    out_row      = r_pend_valid ? r_pend_row : 8'd0;
                    out_col      = r_pend_valid ? r_pend_col : 8'd0;
                    n_pend_valid = 1'b0;
                    n_state      = ogne_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ogne_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ogne_pkg::ST_IDLE;
            r_ev_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ev_valid   <= n_ev_valid;
            r_pend_valid <= n_pend_valid;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_row  <= i_in_cell_row;
            r_col  <= i_in_cell_col;
            r_nb   <= i_in_new_blocked;
            r_diag <= i_in_diagonal;
        end
        r_step     <= n_step;
        r_card     <= n_card;
        r_pend_row <= n_pend_row;
        r_pend_col <= n_pend_col;
        if (adv) begin
            r_ev_inside <= cand_inside;
            r_ev_step   <= r_step;
            r_ev_row    <= cand_row[7:0];
            r_ev_col    <= cand_col[7:0];
        end
        if (out_load) begin
            r_out_status       <= out_status;
            r_out_cell_blocked <= out_cell_blocked;
            r_out_found        <= out_found;
            r_out_row          <= out_row;
            r_out_col          <= out_col;
            r_out_last         <= out_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_status       = r_out_status;
    assign o_out_cell_blocked = r_out_cell_blocked;
    assign o_out_found        = r_out_found;
    assign o_out_nbr_row      = r_out_row;
    assign o_out_nbr_col      = r_out_col;
    assign o_out_last         = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a command occupies the sequencer, so the input is not ready in the cycle after it is accepted
    `OGNE_ASSERT(a_busy_after_accept, i_clk, i_rst_n, in_accept |=> !o_in_ready)
    // only the final result of a command may be empty
    `OGNE_ASSERT(a_nonlast_found, i_clk, i_rst_n, (r_out_valid && !r_out_last) |-> r_out_found)
    // a neighbor result never carries set/query status
    `OGNE_NEVER(a_found_clean, i_clk, i_rst_n,
        r_out_valid && r_out_found && (r_out_status || r_out_cell_blocked))
    // no map write can be lost to the clearing sweep
    `OGNE_NEVER(a_write_during_clear, i_clk, i_rst_n, map_we && map_clearing)

endmodule

### verif/ogne_result_checker.sv
// ----------------------------------------------------------------------------
// ogne_result_checker
// Watches both channels of the grid expander, keeps its own copy of the
// blocked map and bounds, predicts every result and compares in order.
// ----------------------------------------------------------------------------
module ogne_result_checker #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration port
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_index,
    input  logic [ogne_pkg::CFG_W-1:0] i_cfg_data,
    // input channel
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [1:0]                 i_in_cmd,
    input  logic [7:0]                 i_in_cell_row,
    input  logic [7:0]                 i_in_cell_col,
    input  logic                       i_in_new_blocked,
    input  logic                       i_in_diagonal,
    // output channel
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_out_status,
    input  logic                       i_out_cell_blocked,
    input  logic                       i_out_found,
    input  logic [7:0]                 i_out_nbr_row,
    input  logic [7:0]                 i_out_nbr_col,
    input  logic                       i_out_last,
    // status toward the testbench top
    output int                         o_fail_count,
    output int                         o_results_due,
    output int                         o_results_checked
);

    localparam int MAP_CELLS  = MAX_ROWS * MAX_COLS;

    // Step order: up, right, down, left, then up-left, up-right, down-right, down-left
    localparam int ROW_DELTA [0:7] = '{-1, 0, 1, 0, -1, -1, 1, 1};
    localparam int COL_DELTA [0:7] = '{0, 1, 0, -1, -1, 1, 1, -1};

    typedef struct packed {
        logic       status;
        logic       cell_blocked;
        logic       found;
        logic [7:0] nbr_row;
        logic [7:0] nbr_col;
        logic       last;
    } t_grid_result;

    bit           cell_map [0:MAP_CELLS-1];
    logic [8:0]   row_limit;
    logic [8:0]   col_limit;
    t_grid_result grid_results_due [$];
    int           fail_total = 0;

    assign o_fail_count = fail_total;

    // One printed line per failure
    task automatic log_failure(input string msg);
        fail_total++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Cell inside the configured bounds; counts above the maximum saturate
    function automatic bit cell_in_grid(input int r, input int c);
        int rows_eff;
        int cols_eff;
        rows_eff = (row_limit > MAX_ROWS) ? MAX_ROWS : int'(row_limit);
        cols_eff = (col_limit > MAX_COLS) ? MAX_COLS : int'(col_limit);
        return r >= 0 && c >= 0 && r < rows_eff && c < cols_eff;
    endfunction

    function automatic bit cell_open(input int r, input int c);
        return cell_in_grid(r, c) && !cell_map[r * MAX_COLS + c];
    endfunction

    // Apply one command to the map and queue the results it should produce
    task automatic model_grid_command(input ogne_pkg::t_cmd cmd, input int r, input int c,
                                      input bit blk, input bit diag);
        t_grid_result res;
        bit [7:0]     open_dirs;
        int           total;
        int           emitted;
        int           k;
        res = '0;
        res.last = 1'b1;
        if (cmd == ogne_pkg::CMD_NBR) begin
            // first pass finds qualifying moves, second emits them in order
            open_dirs = '0;
            for (k = 0; k < (diag ? 8 : 4); k++) begin
                open_dirs[k] = cell_open(r + ROW_DELTA[k], c + COL_DELTA[k]);
                // diagonal only when both adjoining cardinal cells are free
                if (k >= 4) begin
                    open_dirs[k] = open_dirs[k] && cell_open(r + ROW_DELTA[k], c)
                                   && cell_open(r, c + COL_DELTA[k]);
                end
            end
            total = $countones(open_dirs);
            emitted = 0;
            for (k = 0; k < 8; k++) begin
                if (open_dirs[k]) begin
                    res = '0;
                    res.found   = 1'b1;
                    res.nbr_row = 8'((r + ROW_DELTA[k]) & 255);
                    res.nbr_col = 8'((c + COL_DELTA[k]) & 255);
                    res.last    = (emitted == total - 1);
                    grid_results_due = {grid_results_due, res};
                    emitted++;
                end
            end
            if (total == 0) begin
                grid_results_due = {grid_results_due, res};
            end
        end else begin
            case (cmd)
                ogne_pkg::CMD_SET: begin
                    if (!cell_in_grid(r, c)) res.status = 1'b1;
                    else cell_map[r * MAX_COLS + c] = blk;
                end
                ogne_pkg::CMD_QUERY: begin
                    if (!cell_in_grid(r, c)) res.status = 1'b1;
                    else res.cell_blocked = cell_map[r * MAX_COLS + c];
                end
                default: ; // unused code gives an empty final result
            endcase
            grid_results_due = {grid_results_due, res};
        end
    endtask

    // Mirror config writes, check results, then model accepted commands
    always @(posedge i_clk) begin : channel_watch
        t_grid_result want;
        if (!i_rst_n) begin
            foreach (cell_map[a]) cell_map[a] = 1'b0;
            row_limit = ogne_pkg::CFG_RST_VAL;
            col_limit = ogne_pkg::CFG_RST_VAL;
            grid_results_due.delete();
            o_results_due     <= 0;
            o_results_checked <= 0;
        end else begin
            if (i_cfg_we) begin
                if (ogne_pkg::t_reg_idx'(i_cfg_index) == ogne_pkg::REG_ROW_COUNT)
                    row_limit = i_cfg_data;
                else col_limit = i_cfg_data;
            end

            if (i_out_valid && i_out_ready) begin
                o_results_checked <= o_results_checked + 1;
                if (grid_results_due.size() == 0) begin
                    log_failure($sformatf("unexpected result found=%0d row=%0d col=%0d",
                                          i_out_found, i_out_nbr_row, i_out_nbr_col));
                end else begin
                    want = grid_results_due.pop_front();
                    if (i_out_status !== want.status)
                        log_failure($sformatf("status got %0d want %0d",
                                              i_out_status, want.status));
                    if (i_out_cell_blocked !== want.cell_blocked)
                        log_failure($sformatf("cell_blocked got %0d want %0d",
                                              i_out_cell_blocked, want.cell_blocked));
                    if (i_out_found !== want.found)
                        log_failure($sformatf("found got %0d want %0d",
                                              i_out_found, want.found));
                    if (i_out_nbr_row !== want.nbr_row)
                        log_failure($sformatf("nbr_row got %0d want %0d",
                                              i_out_nbr_row, want.nbr_row));
                    if (i_out_nbr_col !== want.nbr_col)
                        log_failure($sformatf("nbr_col got %0d want %0d",
                                              i_out_nbr_col, want.nbr_col));
                    if (i_out_last !== want.last)
                        log_failure($sformatf("last got %0d want %0d",
                                              i_out_last, want.last));
                end
            end

            if (i_in_valid && i_in_ready) begin
                model_grid_command(ogne_pkg::t_cmd'(i_in_cmd), i_in_cell_row, i_in_cell_col,
                                   i_in_new_blocked, i_in_diagonal);
            end

            o_results_due <= grid_results_due.size();
        end
    end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the occupancy grid expander: directed corner cases, then
// random command streams clustered around grid corners under several bound
// settings, with bursty input and a stalling receiver. Checking is done by
// ogne_result_checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 4;
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_HOLD_CYCLES = 400;
    // clearing sweep after reset runs with no transaction
    localparam int WATCHDOG_LIMIT   = 200000;
    localparam int PHASES           = 9;
    localparam int PHASE_ROWS  [0:PHASES-1] = '{256, 6, 511, 1, 200, 0, 255, 3, 256};
    localparam int PHASE_COLS  [0:PHASES-1] = '{256, 9, 300, 256, 1, 256, 255, 3, 256};
    localparam int PHASE_ITEMS [0:PHASES-1] = '{55, 50, 50, 30, 30, 15, 50, 40, 35};

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [0:0]                 i_cfg_index;
    logic [ogne_pkg::CFG_W-1:0] i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [1:0]                 i_in_cmd;
    logic [7:0]                 i_in_cell_row;
    logic [7:0]                 i_in_cell_col;
    logic                       i_in_new_blocked;
    logic                       i_in_diagonal;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic                       o_out_status;
    logic                       o_out_cell_blocked;
    logic                       o_out_found;
    logic [7:0]                 o_out_nbr_row;
    logic [7:0]                 o_out_nbr_col;
    logic                       o_out_last;

    int fail_count;
    int results_due;
    int results_checked;
    bit hold_off_req;
    bit hold_off_done;
    int burst_left;
    int bound_settings;
    int cmd_tally [0:3];

    occupancy_grid_neighbor_expander_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_in_cmd           (i_in_cmd),
        .i_in_cell_row      (i_in_cell_row),
        .i_in_cell_col      (i_in_cell_col),
        .i_in_new_blocked   (i_in_new_blocked),
        .i_in_diagonal      (i_in_diagonal),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_status       (o_out_status),
        .o_out_cell_blocked (o_out_cell_blocked),
        .o_out_found        (o_out_found),
        .o_out_nbr_row      (o_out_nbr_row),
        .o_out_nbr_col      (o_out_nbr_col),
        .o_out_last         (o_out_last)
    );

    ogne_result_checker checker_i (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_in_cmd           (i_in_cmd),
        .i_in_cell_row      (i_in_cell_row),
        .i_in_cell_col      (i_in_cell_col),
        .i_in_new_blocked   (i_in_new_blocked),
        .i_in_diagonal      (i_in_diagonal),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_out_status       (o_out_status),
        .i_out_cell_blocked (o_out_cell_blocked),
        .i_out_found        (o_out_found),
        .i_out_nbr_row      (o_out_nbr_row),
        .i_out_nbr_col      (o_out_nbr_col),
        .i_out_last         (o_out_last),
        .o_fail_count       (fail_count),
        .o_results_due      (results_due),
        .o_results_checked  (results_checked)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Receiver: a random sequence of stall patterns,
    // plus one long hold-off on request from the stimulus
    initial begin : receiver
        int mode;
        int span;
        int n;
        hold_off_done = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            if (hold_off_req && !hold_off_done) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_off_done = 1'b1;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 80);
                for (n = 0; n < span; n++) begin
                    case (mode)
                        0: i_out_ready <= 1'b1;
                        1: i_out_ready <= 1'($urandom_range(0, 1));
                        2: i_out_ready <= ($urandom_range(0, 3) == 0);
                        default: i_out_ready <= (n % 3 == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL occupancy_grid_neighbor_expander_core");
        $finish;
    end

    // Offer one command and wait for its transaction; bursts and gaps
    task automatic send_cmd(input ogne_pkg::t_cmd cmd, input int row, input int col,
                            input bit blk, input bit diag);
        int gap;
        i_in_valid       <= 1'b1;
        i_in_cmd         <= cmd;
        i_in_cell_row    <= row[7:0];
        i_in_cell_col    <= col[7:0];
        i_in_new_blocked <= blk;
        i_in_diagonal    <= diag;
        do @(posedge i_clk); while (!o_in_ready);
        cmd_tally[cmd]++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every predicted result has come out
    task automatic settle_outputs();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both bound registers while the block is idle
    task automatic set_bounds(input int rows, input int cols);
        settle_outputs();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ogne_pkg::REG_ROW_COUNT;
        i_cfg_data  <= rows[ogne_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= ogne_pkg::REG_COL_COUNT;
        i_cfg_data  <= cols[ogne_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        bound_settings++;
    endtask

    // Main stimulus
    initial begin : stimulus
        int             phase;
        int             k;
        int             rows_eff;
        int             cols_eff;
        int             base_r;
        int             base_c;
        int             row;
        int             col;
        int             pick;
        ogne_pkg::t_cmd cmd;

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= ogne_pkg::REG_ROW_COUNT;
        i_cfg_data       <= '0;
        i_in_valid       <= 1'b0;
        i_in_cmd         <= ogne_pkg::CMD_SET;
        i_in_cell_row    <= '0;
        i_in_cell_col    <= '0;
        i_in_new_blocked <= 1'b0;
        i_in_diagonal    <= 1'b0;
        hold_off_req     = 1'b0;
        burst_left       = 0;
        bound_settings   = 0;
        foreach (cmd_tally[i]) cmd_tally[i] = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_bounds(256, 256);

        // Directed: full grid, origin and far corner
        send_cmd(ogne_pkg::CMD_QUERY, 0, 0, 1'b0, 1'b0);
        send_cmd(ogne_pkg::CMD_SET, 0, 0, 1'b1, 1'b0);
        send_cmd(ogne_pkg::CMD_QUERY, 0, 0, 1'b0, 1'b0);
        send_cmd(ogne_pkg::CMD_NBR, 0, 0, 1'b0, 1'b1);
        send_cmd(ogne_pkg::CMD_SET, 255, 255, 1'b1, 1'b0);
        // up-right would cut the blocked corner cell
        send_cmd(ogne_pkg::CMD_NBR, 255, 254, 1'b0, 1'b1);
        // blocked center is not itself checked
        send_cmd(ogne_pkg::CMD_NBR, 255, 255, 1'b0, 1'b0);
        send_cmd(ogne_pkg::CMD_NONE, 255, 255, 1'b1, 1'b1);
        // walled-in point gives one empty result, diagonals all cut
        send_cmd(ogne_pkg::CMD_SET, 9, 10, 1'b1, 1'b0);
        send_cmd(ogne_pkg::CMD_SET, 10, 11, 1'b1, 1'b0);
        send_cmd(ogne_pkg::CMD_SET, 11, 10, 1'b1, 1'b0);
        send_cmd(ogne_pkg::CMD_SET, 10, 9, 1'b1, 1'b0);
        send_cmd(ogne_pkg::CMD_NBR, 10, 10, 1'b0, 1'b1);
        send_cmd(ogne_pkg::CMD_SET, 10, 11, 1'b0, 1'b0);
        send_cmd(ogne_pkg::CMD_NBR, 10, 10, 1'b0, 1'b1);
        send_cmd(ogne_pkg::CMD_QUERY, 128, 127, 1'b0, 1'b0);
        send_cmd(ogne_pkg::CMD_SET, 0, 0, 1'b0, 1'b0);

        // Zero rows and columns: everything out of bounds
        set_bounds(0, 0);
        send_cmd(ogne_pkg::CMD_SET, 0, 0, 1'b1, 1'b0);
        send_cmd(ogne_pkg::CMD_QUERY, 0, 0, 1'b0, 1'b0);
        send_cmd(ogne_pkg::CMD_NBR, 5, 5, 1'b0, 1'b1);

        // Counts above the maximum saturate; map survives bound changes
        set_bounds(511, 511);
        send_cmd(ogne_pkg::CMD_QUERY, 255, 255, 1'b0, 1'b0);
        send_cmd(ogne_pkg::CMD_NBR, 254, 255, 1'b0, 1'b1);

        // Single-cell grid
        set_bounds(1, 1);
        send_cmd(ogne_pkg::CMD_NBR, 0, 0, 1'b0, 1'b1);
        send_cmd(ogne_pkg::CMD_SET, 0, 1, 1'b1, 1'b0);
        send_cmd(ogne_pkg::CMD_QUERY, 0, 0, 1'b0, 1'b0);

        // Random phases: commands clustered near corners of the active area
        for (phase = 0; phase < PHASES; phase++) begin
            set_bounds(PHASE_ROWS[phase], PHASE_COLS[phase]);
            rows_eff = (PHASE_ROWS[phase] > 256) ? 256 : PHASE_ROWS[phase];
            cols_eff = (PHASE_COLS[phase] > 256) ? 256 : PHASE_COLS[phase];
            for (k = 0; k < PHASE_ITEMS[phase]; k++) begin
                if (k % 16 == 0) begin
                    if ($urandom_range(0, 2) == 0) begin
                        base_r = $urandom_range(0, 255);
                        base_c = $urandom_range(0, 255);
                    end else begin
                        base_r = ($urandom_range(0, 1) != 0) ? rows_eff - 1 : 0;
                        base_c = ($urandom_range(0, 1) != 0) ? cols_eff - 1 : 0;
                    end
                end
                // long receiver hold-off while the sender keeps offering
                if (phase == 0 && k == 10) hold_off_req = 1'b1;
                // sender pause mid-phase until the output side is empty
                if (phase == 0 && k == 40) settle_outputs();

                pick = $urandom_range(0, 99);
                cmd = (pick < 30) ? ogne_pkg::CMD_SET : (pick < 50) ? ogne_pkg::CMD_QUERY :
                      (pick < 95) ? ogne_pkg::CMD_NBR : ogne_pkg::CMD_NONE;
                if ($urandom_range(0, 4) == 0) begin
                    row = $urandom_range(0, 255);
                    col = $urandom_range(0, 255);
                end else begin
                    row = (base_r + int'($urandom_range(0, 6)) - 3) & 255;
                    col = (base_c + int'($urandom_range(0, 6)) - 3) & 255;
                end
                send_cmd(cmd, row, col, ($urandom_range(0, 9) < 6),
                         1'($urandom_range(0, 1)));
            end
        end

        settle_outputs();
        $display("Covered %0d set, %0d query, %0d neighbor and %0d unused-code commands,",
                 cmd_tally[ogne_pkg::CMD_SET], cmd_tally[ogne_pkg::CMD_QUERY],
                 cmd_tally[ogne_pkg::CMD_NBR], cmd_tally[ogne_pkg::CMD_NONE]);
        $display("%0d results checked across %0d bound settings, %0d mismatches",
                 results_checked, bound_settings, fail_count);
        if (fail_count == 0) begin
            $display("PASS occupancy_grid_neighbor_expander_core");
        end else begin
            $display("FAIL occupancy_grid_neighbor_expander_core");
        end
        $finish;
    end

endmodule
